// ===== src/lsfh_pkg.sv =====
// Shared types, codes and the classic checksum for the LIN slave frame handler.
package lsfh_pkg;

    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;
    localparam int IDX_LSB    = 3;
    localparam int IDX_W      = CFG_ADDR_W - IDX_LSB;

    typedef enum logic [IDX_W-1:0] {
        REG_RECEIVE_ID    = 3'd0,
        REG_RESPOND_ID    = 3'd1,
        REG_SYNC_VALUE    = 3'd2,
        REG_CLOSE_VALUE   = 3'd3,
        REG_RESPONSE_DATA = 3'd4
    } reg_idx_t;

    localparam logic [7:0]  RESET_RECEIVE_ID    = 8'h3A;
    localparam logic [7:0]  RESET_RESPOND_ID    = 8'h3B;
    localparam logic [7:0]  RESET_SYNC_VALUE    = 8'h55;
    localparam logic [7:0]  RESET_CLOSE_VALUE   = 8'h56;
    localparam logic [63:0] RESET_RESPONSE_DATA = 64'h3736353433323130;

    typedef enum logic [1:0] {
        KIND_RESPONSE  = 2'd0,
        KIND_FRAME_OK  = 2'd1,
        KIND_FRAME_BAD = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0]  receive_id;
        logic [7:0]  respond_id;
        logic [7:0]  sync_value;
        logic [7:0]  close_value;
        logic [63:0] response_data;
    } cfg_t;

    typedef struct packed {
        logic        resp;
        logic        good;
        logic [63:0] data;
        logic [15:0] rx_count;
        logic [15:0] tx_count;
    } job_t;

    function automatic logic [7:0] classic_checksum(input logic [10:0] sum);
        logic [8:0] t;
        logic [8:0] folded;
        t = {1'b0, sum[7:0]} + {6'b0, sum[10:8]};
        folded = (t > 9'd255) ? (t - 9'd255) : t;
        return ~folded[7:0];
    endfunction

endpackage

// ===== src/lin_slave_frame_handler.sv =====
// Top level of the LIN slave frame handler.
//
// Received bus bytes enter on the s_ stream, one byte per item. A sync byte
// arms the block for an identifier; the close byte in sync position locks it
// until reset. After the respond identifier the block emits DATA_BYTES
// response bytes and the classic checksum on the m_ stream, tlast on the
// checksum. After the receive identifier it collects DATA_BYTES data bytes
// and a checksum byte, then emits one report item (good or bad).
// The first result of an item passes the input register and then the output
// sequencer's registers, once the output sequencer is free.
// Throughput: one input item per cycle while no result waits; a response burst holds
// the sequencer for its bytes and checksum at one result per cycle while m_tready is
// high, and a byte that raises a result waits in the input register until the sequencer is free.
// A stalled m_tready holds the current result; bytes that raise no result
// keep flowing. Reset clears the state machine, counters and registers to
// their defaults. Registers sit on an APB port at byte address 8 * index.
module lin_slave_frame_handler
#(
    parameter int DATA_BYTES = 8
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lsfh_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [lsfh_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [lsfh_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // rx_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [103:0]                    m_tdata,   // tx_byte, frame_data, rx_count, tx_count
    output logic [1:0]                      m_tuser,   // kind
    output logic                            m_tlast
);

    lsfh_pkg::cfg_t cfg;
    lsfh_pkg::job_t job;
    logic           job_valid;
    logic           job_ready;
    logic [7:0]     tx_byte;
    logic [63:0]    frame_data;
    logic [15:0]    rx_count;
    logic [15:0]    tx_count;

    assign m_tdata = {tx_count, rx_count, frame_data, tx_byte};

    lsfh_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lsfh_core #(.DATA_BYTES(DATA_BYTES)) u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    lsfh_emit #(.DATA_BYTES(DATA_BYTES)) u_emit
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (job_valid),
        .job_ready  (job_ready),
        .job        (job),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .kind       (m_tuser),
        .tx_byte    (tx_byte),
        .last       (m_tlast),
        .frame_data (frame_data),
        .rx_count   (rx_count),
        .tx_count   (tx_count)
    );

endmodule

// ===== src/lsfh_regs.sv =====
// APB configuration registers of the LIN slave frame handler.
module lsfh_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lsfh_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [lsfh_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [lsfh_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    output lsfh_pkg::cfg_t                  cfg
);

    lsfh_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [lsfh_pkg::IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[lsfh_pkg::CFG_ADDR_W-1:lsfh_pkg::IDX_LSB];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.receive_id    <= lsfh_pkg::RESET_RECEIVE_ID;
            cfg_reg.respond_id    <= lsfh_pkg::RESET_RESPOND_ID;
            cfg_reg.sync_value    <= lsfh_pkg::RESET_SYNC_VALUE;
            cfg_reg.close_value   <= lsfh_pkg::RESET_CLOSE_VALUE;
            cfg_reg.response_data <= lsfh_pkg::RESET_RESPONSE_DATA;
        end
        else if (wr_en)
        begin
            case (idx)
                lsfh_pkg::REG_RECEIVE_ID:    cfg_reg.receive_id    <= pwdata[7:0];
                lsfh_pkg::REG_RESPOND_ID:    cfg_reg.respond_id    <= pwdata[7:0];
                lsfh_pkg::REG_SYNC_VALUE:    cfg_reg.sync_value    <= pwdata[7:0];
                lsfh_pkg::REG_CLOSE_VALUE:   cfg_reg.close_value   <= pwdata[7:0];
                lsfh_pkg::REG_RESPONSE_DATA: cfg_reg.response_data <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            lsfh_pkg::REG_RECEIVE_ID:    prdata = {56'b0, cfg_reg.receive_id};
            lsfh_pkg::REG_RESPOND_ID:    prdata = {56'b0, cfg_reg.respond_id};
            lsfh_pkg::REG_SYNC_VALUE:    prdata = {56'b0, cfg_reg.sync_value};
            lsfh_pkg::REG_CLOSE_VALUE:   prdata = {56'b0, cfg_reg.close_value};
            lsfh_pkg::REG_RESPONSE_DATA: prdata = cfg_reg.response_data;
            default:                     prdata = '0;
        endcase
    end

endmodule

// ===== src/lsfh_core.sv =====
// Input register, frame state machine, frame store and counters.
module lsfh_core
#(
    parameter int DATA_BYTES = 8
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  lsfh_pkg::cfg_t cfg,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     in_byte,
    output logic           job_valid,
    input  logic           job_ready,
    output lsfh_pkg::job_t job
);

    localparam int CW = $clog2(DATA_BYTES + 1);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ID,
        PH_RX,
        PH_LOCKED
    } phase_t;

    phase_t                    phase_reg, phase_next;
    logic [CW-1:0]             idx_reg, idx_next;
    logic [10:0]               sum_reg, sum_next;
    logic [15:0]               good_reg, good_next;
    logic [15:0]               sent_reg, sent_next;
    logic                      in_valid_reg;
    logic [7:0]                byte_reg;
    logic [8*DATA_BYTES-1:0]   frame_reg;
    logic                      needs_job;
    logic                      consume;
    logic                      store;
    logic                      good;

    assign good      = (byte_reg == lsfh_pkg::classic_checksum(sum_reg));
    assign consume   = in_valid_reg && (!needs_job || job_ready);
    assign in_ready  = !in_valid_reg || consume;
    assign job_valid = in_valid_reg && needs_job;
    assign store     = consume && (phase_reg == PH_RX) && (idx_reg < CW'(DATA_BYTES));

    always_comb
    begin
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        sum_next     = sum_reg;
        good_next    = good_reg;
        sent_next    = sent_reg;
        needs_job    = 1'b0;
        job.resp     = 1'b0;
        job.good     = good;
        job.data     = 64'(frame_reg);
        job.rx_count = good_reg;
        job.tx_count = sent_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (byte_reg == cfg.sync_value)
                    phase_next = PH_ID;
                else if (byte_reg == cfg.close_value)
                    phase_next = PH_LOCKED;
            end
            PH_ID:
            begin
                if (byte_reg == cfg.respond_id)
                begin
                    needs_job    = 1'b1;
                    job.resp     = 1'b1;
                    job.data     = cfg.response_data;
                    sent_next    = sent_reg + 16'd1;
                    job.tx_count = sent_next;
                    phase_next   = PH_IDLE;
                end
                else if (byte_reg == cfg.receive_id)
                begin
                    phase_next = PH_RX;
                    idx_next   = '0;
                    sum_next   = '0;
                end
                else
                    phase_next = PH_IDLE;
            end
            PH_RX:
            begin
                if (idx_reg < CW'(DATA_BYTES))
                begin
                    sum_next = sum_reg + {3'b0, byte_reg};
                    idx_next = idx_reg + CW'(1);
                end
                else
                begin
                    needs_job    = 1'b1;
                    good_next    = good_reg + {15'b0, good};
                    job.rx_count = good_next;
                    phase_next   = PH_IDLE;
                    idx_next     = '0;
                    sum_next     = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            idx_reg      <= '0;
            sum_reg      <= '0;
            good_reg     <= '0;
            sent_reg     <= '0;
            in_valid_reg <= 1'b0;
        end
        else
        begin
            if (consume)
            begin
                phase_reg <= phase_next;
                idx_reg   <= idx_next;
                sum_reg   <= sum_next;
                good_reg  <= good_next;
                sent_reg  <= sent_next;
            end
            if (in_ready)
                in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            byte_reg <= in_byte;
    end

    for (genvar i = 0; i < DATA_BYTES; i++)
    begin : g_frame
        always_ff @(posedge clk)
        begin
            if (store && (idx_reg == CW'(i)))
                frame_reg[8*i +: 8] <= byte_reg;
        end
    end

endmodule

// ===== src/lsfh_emit.sv =====
// Result sequencer: plays out a response burst or one frame report.
module lsfh_emit
#(
    parameter int DATA_BYTES = 8
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    output logic           job_ready,
    input  lsfh_pkg::job_t job,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [1:0]     kind,
    output logic [7:0]     tx_byte,
    output logic           last,
    output logic [63:0]    frame_data,
    output logic [15:0]    rx_count,
    output logic [15:0]    tx_count
);

    localparam int CW = $clog2(DATA_BYTES + 1);

    logic          busy_reg;
    logic          resp_reg;
    logic          good_reg;
    logic [CW-1:0] cnt_reg;
    logic [63:0]   data_reg;
    logic [10:0]   sum_reg;
    logic [15:0]   rxc_reg;
    logic [15:0]   txc_reg;
    logic          last_item;
    logic          fire;
    logic          load;

    assign last_item = !resp_reg || (cnt_reg == CW'(DATA_BYTES));
    assign fire      = busy_reg && out_ready;
    assign job_ready = !busy_reg || (out_ready && last_item);
    assign load      = job_valid && job_ready;

    assign out_valid  = busy_reg;
    assign last       = last_item;
    assign rx_count   = rxc_reg;
    assign tx_count   = txc_reg;
    assign frame_data = resp_reg ? 64'b0 : data_reg;

    always_comb
    begin
        if (resp_reg)
            kind = lsfh_pkg::KIND_RESPONSE;
        else if (good_reg)
            kind = lsfh_pkg::KIND_FRAME_OK;
        else
            kind = lsfh_pkg::KIND_FRAME_BAD;
        if (!resp_reg)
            tx_byte = 8'b0;
        else if (last_item)
            tx_byte = lsfh_pkg::classic_checksum(sum_reg);
        else
            tx_byte = data_reg[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else if (load)
            busy_reg <= 1'b1;
        else if (fire && last_item)
            busy_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            resp_reg <= job.resp;
            good_reg <= job.good;
            data_reg <= job.data;
            rxc_reg  <= job.rx_count;
            txc_reg  <= job.tx_count;
            cnt_reg  <= '0;
            sum_reg  <= '0;
        end
        else if (fire && !last_item)
        begin
            data_reg <= {8'b0, data_reg[63:8]};
            sum_reg  <= sum_reg + {3'b0, data_reg[7:0]};
            cnt_reg  <= cnt_reg + CW'(1);
        end
    end

endmodule
